// ----- hdl/dfhe_pkg.sv -----
// Shared types, code tables and helper functions for the fixed-Huffman token encoder.
package dfhe_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int TOK_BITS    = 31;
    localparam int WORK_BITS   = 38;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_LITERAL = 2'd1,
        CMD_MATCH   = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    // One classified token: its bits in stream order (bit 0 goes out first).
    typedef struct packed {
        logic [TOK_BITS-1:0] bits;
        logic [4:0]          nbits;
        logic                align;
    } t_tok;

    localparam logic [7:0]  LIT_BASE_LO = 8'h30;
    localparam logic [8:0]  LIT_BASE_HI = 9'h190;
    localparam logic [7:0]  LEN_CODE_HI = 8'hC0;
    localparam logic [7:0]  LIT_SPLIT   = 8'd144;
    localparam logic [4:0]  LEN_SPLIT   = 5'd23;

    localparam logic [8:0] LEN_FIRST [0:28] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_XBITS [0:28] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_FIRST [0:29] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
        16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
        16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_XBITS [0:29] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    function automatic logic [4:0] len_sym(input logic [8:0] len);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 0; i < 29; i++) begin
            if (len >= LEN_FIRST[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    function automatic logic [4:0] dist_sym(input logic [15:0] distance);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 0; i < 30; i++) begin
            if (distance >= DIST_FIRST[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    // Reverse the low n bits of a code so its top bit goes out first.
    function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] n);
        logic [8:0] t;
        logic [8:0] r;
        t = code << (4'd9 - n);
        for (int i = 0; i < 9; i++) begin
            r[i] = t[8-i];
        end
        return r;
    endfunction

endpackage

// ----- hdl/dfhe_front.sv -----
// Front end: classifies each token and builds its bit string in stream order.
module dfhe_front (
    input  logic              i_in_valid,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_literal_byte,
    input  logic [8:0]        i_match_length,
    input  logic [15:0]       i_match_distance,
    input  logic              i_q_full,
    output logic              o_push,
    output dfhe_pkg::t_tok    o_tok
);
    import dfhe_pkg::*;

    logic [8:0]  len_c;
    logic [15:0] dist_c;
    logic [4:0]  ls;
    logic [4:0]  ds;
    logic [8:0]  code;
    logic [3:0]  code_n;
    logic [8:0]  rcode;
    logic [4:0]  lext;
    logic [2:0]  lx;
    logic [12:0] dext;
    logic [3:0]  dx;
    logic [4:0]  drev;
    logic [4:0]  pos_l;
    logic [4:0]  pos_d;
    logic [4:0]  pos_x;
    logic [15:0] dist_diff;
    logic [8:0]  len_diff;

    assign o_push = i_in_valid && !i_q_full;

    always_comb begin
        len_c = i_match_length;
        if (len_c < 9'd3) begin
            len_c = 9'd3;
        end else if (len_c > 9'd258) begin
            len_c = 9'd258;
        end
        dist_c = i_match_distance;
        if (dist_c == 16'd0) begin
            dist_c = 16'd1;
        end else if (dist_c > 16'd32768) begin
            dist_c = 16'd32768;
        end
        ls        = len_sym(len_c);
        ds        = dist_sym(dist_c);
        len_diff  = len_c - LEN_FIRST[ls];
        dist_diff = dist_c - DIST_FIRST[ds];
        lext      = len_diff[4:0];
        lx        = LEN_XBITS[ls];
        dext      = dist_diff[12:0];
        dx        = DIST_XBITS[ds];
        for (int i = 0; i < 5; i++) begin
            drev[i] = ds[4-i];
        end

        code   = 9'd0;
        code_n = 4'd7;
        o_tok  = '0;
        unique case (t_cmd'(i_command))
            CMD_HEADER: begin
                o_tok.bits  = TOK_BITS'(3'b011);
                o_tok.nbits = 5'd3;
            end
            CMD_LITERAL: begin
                if (i_literal_byte < LIT_SPLIT) begin
                    code   = {1'b0, LIT_BASE_LO + i_literal_byte};
                    code_n = 4'd8;
                end else begin
                    code   = LIT_BASE_HI + {1'b0, i_literal_byte - LIT_SPLIT};
                    code_n = 4'd9;
                end
            end
            CMD_MATCH: begin
                // Length symbols 257..279 take 7 bits, 280..285 take 8.
                if (ls < LEN_SPLIT) begin
                    code   = {4'd0, ls + 5'd1};
                    code_n = 4'd7;
                end else begin
                    code   = {1'b0, LEN_CODE_HI + {3'd0, ls - LEN_SPLIT}};
                    code_n = 4'd8;
                end
            end
            CMD_END: begin
                o_tok.nbits = 5'd7;
                o_tok.align = 1'b1;
            end
        endcase

        rcode = rev_code(code, code_n);
        pos_l = {1'b0, code_n};
        pos_d = pos_l + {2'd0, lx};
        pos_x = pos_d + 5'd5;
        if (t_cmd'(i_command) == CMD_LITERAL) begin
            o_tok.bits  = TOK_BITS'(rcode);
            o_tok.nbits = pos_l;
        end else if (t_cmd'(i_command) == CMD_MATCH) begin
            o_tok.bits  = TOK_BITS'(rcode)
                        | (TOK_BITS'(lext) << pos_l)
                        | (TOK_BITS'(drev) << pos_d)
                        | (TOK_BITS'(dext) << pos_x);
            o_tok.nbits = pos_x + {1'b0, dx};
        end
    end

endmodule

// ----- hdl/dfhe_queue.sv -----
// Short token queue between the front end and the bit packer.
module dfhe_queue #(
    parameter int DEPTH = dfhe_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dfhe_pkg::t_tok i_tok,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output dfhe_pkg::t_tok o_tok
);
    import dfhe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

endmodule

// ----- hdl/dfhe_back.sv -----
// Back end: merges token bits with pending bits and sends one byte per cycle while the output is not stalled.
module dfhe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dfhe_pkg::t_tok i_tok,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_run
);
    import dfhe_pkg::*;

    logic [WORK_BITS-1:0] r_work;
    logic [2:0]           r_nbytes;
    logic [2:0]           r_cnt;
    logic                 r_out_valid;
    logic [7:0]           r_byte;
    logic                 r_last;

    logic [WORK_BITS-1:0] n_work;
    logic [2:0]           n_nbytes;
    logic [2:0]           n_cnt;
    logic                 n_out_valid;
    logic [7:0]           n_byte;
    logic                 n_last;

    logic                 out_free;
    logic                 emit;
    logic [WORK_BITS-1:0] work_a;
    logic [2:0]           nb_a;
    logic [WORK_BITS-1:0] merged;
    logic [5:0]           total;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        emit     = out_free && (r_nbytes != 3'd0);
        work_a   = emit ? (r_work >> 8) : r_work;
        nb_a     = r_nbytes - {2'd0, emit};
        o_pop    = (nb_a == 3'd0) && i_q_valid;
        merged   = (WORK_BITS'(i_tok.bits) << r_cnt) | WORK_BITS'(work_a[6:0]);
        total    = {3'd0, r_cnt} + {1'b0, i_tok.nbits};

        n_work      = work_a;
        n_nbytes    = nb_a;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_last      = r_last;

        if (emit) begin
            n_out_valid = 1'b1;
            n_byte      = r_work[7:0];
            n_last      = (r_nbytes == 3'd1);
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_work = merged;
            // Pad a partial byte with zeros on end of block.
            if (i_tok.align && (total[2:0] != 3'd0)) begin
                n_nbytes = total[5:3] + 3'd1;
                n_cnt    = 3'd0;
            end else begin
                n_nbytes = total[5:3];
                n_cnt    = total[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= '0;
            r_nbytes    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_work      <= n_work;
            r_nbytes    <= n_nbytes;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

endmodule

// ----- hdl/deflate_fixed_huffman_token_encoder.sv -----
// An accepted token goes through the token queue, the bit packer's work register and its
// output register. The packer sends one byte per cycle while the output is not stalled and
// takes the next token only when no whole byte of the last one is left to send.
// The token queue (QUEUE_DEPTH entries) lets input acceptance run ahead of the packer.
// Reset (synchronous, active low) empties the queue, clears the pending bits and
// drops any byte waiting at the output.
module deflate_fixed_huffman_token_encoder #(
    parameter int QUEUE_DEPTH = dfhe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_literal_byte,
    input  logic [8:0]  i_match_length,
    input  logic [15:0] i_match_distance,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);
    import dfhe_pkg::*;

    logic push;
    logic q_full;
    logic q_valid;
    logic pop;
    t_tok front_tok;
    t_tok q_tok;

    assign o_in_stall = q_full;

    dfhe_front u_front (
        .i_in_valid       (i_in_valid),
        .i_command        (i_command),
        .i_literal_byte   (i_literal_byte),
        .i_match_length   (i_match_length),
        .i_match_distance (i_match_distance),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_tok            (front_tok)
    );

    dfhe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (front_tok),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    dfhe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_tok         (q_tok),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- hdl/dfhe_checker.sv -----
// Port-level checks for the fixed-Huffman token encoder, bound to the top level.
module dfhe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run
);

    // A stalled byte holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last_of_run))
        else $error("stalled output transaction changed");

    // Bytes of one token follow each other without gaps.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid)
        else $error("gap inside a token's byte run");

    // The queue fills only through an accepted transaction.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted transaction");

    // Reset drops any waiting byte.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or stall set after reset");

endmodule

bind deflate_fixed_huffman_token_encoder dfhe_checker u_dfhe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);
